// ===== hw/rtl/waveset_segmenter_top_macros.svh =====
// Assertion macros for the top RTL file of the waveset segmenter.
`ifndef WAVESET_SEGMENTER_TOP_MACROS_SVH
`define WAVESET_SEGMENTER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Checked at every clock edge outside reset.
`define WSS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define WSS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define WSS_ASSERT(label, clk, rst, prop, msg)
`define WSS_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== hw/rtl/wss_pkg.sv =====
`timescale 1ns / 1ps

package wss_pkg;

  localparam int INDEX_W  = 16;
  localparam int LENGTH_W = 17;
  localparam int PEAK_W   = 24;

  typedef struct packed {
    logic [INDEX_W-1:0]  head_index;
    logic [INDEX_W-1:0]  tail_index;
    logic [LENGTH_W-1:0] length;
    logic [PEAK_W-1:0]   peak;
  } wss_result_t;

endpackage

// ===== hw/rtl/wss_core.sv =====
`timescale 1ns / 1ps

module wss_core
  import wss_pkg::*;
#(
  parameter int MAX_BUFFER  = 65536,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   last_sample,
  output logic                   emit,
  output wss_result_t            result
);

  localparam int IndexLimit = (1 << INDEX_W) - 1;
  localparam int IdxMaxInt  = (MAX_BUFFER - 1 < IndexLimit) ? MAX_BUFFER - 1 : IndexLimit;
  localparam logic [INDEX_W-1:0] IdxMax = INDEX_W'(IdxMaxInt);

  logic [SAMPLE_BITS-1:0] previous_sample;
  logic                   have_previous;
  logic                   take_next_crossing;
  logic                   waveset_open;
  logic [INDEX_W-1:0]     open_start;
  logic [INDEX_W-1:0]     sample_index;
  logic [SAMPLE_BITS-1:0] running_peak;
  logic                   overflowed;

  logic                   take_next_crossing_next;
  logic                   waveset_open_next;
  logic [INDEX_W-1:0]     open_start_next;
  logic [INDEX_W-1:0]     sample_index_next;
  logic [SAMPLE_BITS-1:0] running_peak_next;
  logic                   overflowed_next;

  logic                   cur_pos;
  logic                   cur_neg;
  logic                   prev_pos;
  logic                   prev_neg;
  logic                   crossing;
  logic                   boundary;
  logic [SAMPLE_BITS-1:0] prev_mag;
  logic [INDEX_W-1:0]     end_idx;

  always_comb begin
    cur_neg  = sample[SAMPLE_BITS-1];
    cur_pos  = !sample[SAMPLE_BITS-1] && (|sample);
    prev_neg = previous_sample[SAMPLE_BITS-1];
    prev_pos = !previous_sample[SAMPLE_BITS-1] && (|previous_sample);
    crossing = have_previous && ((prev_neg && cur_pos) || (prev_pos && cur_neg));
    boundary = !overflowed && crossing && take_next_crossing;
    emit     = boundary && waveset_open;
    prev_mag = previous_sample[SAMPLE_BITS-1] ? (~previous_sample + 1'b1) : previous_sample;
    end_idx  = sample_index - INDEX_W'(2);

    result.head_index = open_start;
    result.tail_index = end_idx;
    result.length     = {1'b0, end_idx} - {1'b0, open_start} + LENGTH_W'(1);
    result.peak       = PEAK_W'(running_peak);
  end

  always_comb begin
    take_next_crossing_next = take_next_crossing;
    waveset_open_next       = waveset_open;
    open_start_next         = open_start;
    running_peak_next       = running_peak;
    sample_index_next       = sample_index;
    overflowed_next         = overflowed;
    if (crossing) begin
      take_next_crossing_next = !take_next_crossing;
    end
    if (boundary) begin
      waveset_open_next = 1'b1;
      open_start_next   = sample_index - INDEX_W'(1);
      running_peak_next = prev_mag;
    end else if (have_previous && prev_mag > running_peak) begin
      running_peak_next = prev_mag;
    end
    if (sample_index < IdxMax) begin
      sample_index_next = sample_index + INDEX_W'(1);
    end else begin
      overflowed_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_sample)) begin
      previous_sample    <= '0;
      have_previous      <= 1'b0;
      take_next_crossing <= 1'b1;
      waveset_open       <= 1'b0;
      open_start         <= '0;
      sample_index       <= '0;
      running_peak       <= '0;
      overflowed         <= 1'b0;
    end else if (step && !overflowed) begin
      previous_sample    <= sample;
      have_previous      <= 1'b1;
      take_next_crossing <= take_next_crossing_next;
      waveset_open       <= waveset_open_next;
      open_start         <= open_start_next;
      sample_index       <= sample_index_next;
      running_peak       <= running_peak_next;
      overflowed         <= overflowed_next;
    end
  end

endmodule

// ===== hw/rtl/waveset_segmenter_top.sv =====
// A closing sample is held in the input register, its result then in the result register.
// Throughput: one sample per cycle unless a closing sample finds the result register full;
// an input and a result register let a new sample enter while a waveset awaits transfer.
// The sign compare and peak update sit between the input register and the result register.
// Reset (synchronous, active high) empties both registers and returns the segmenter state.
`timescale 1ns / 1ps
`include "waveset_segmenter_top_macros.svh"

module waveset_segmenter_top
  import wss_pkg::*;
#(
  parameter int MAX_BUFFER  = 65536,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   last_sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [INDEX_W-1:0]     head_index,
  output logic [INDEX_W-1:0]     tail_index,
  output logic [LENGTH_W-1:0]    length,
  output logic [PEAK_W-1:0]      peak
);

  logic                   s1_valid;
  logic [SAMPLE_BITS-1:0] s1_sample;
  logic                   s1_last;
  logic                   emit;
  logic                   fire;
  logic                   out_free;
  wss_result_t            result;

  wss_core #(
    .MAX_BUFFER  (MAX_BUFFER),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (fire),
    .sample      (s1_sample),
    .last_sample (s1_last),
    .emit        (emit),
    .result      (result)
  );

  assign out_free = !out_valid || out_ready;
  assign fire     = s1_valid && (!emit || out_free);
  assign in_ready = !s1_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample <= sample;
      s1_last   <= last_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      head_index <= result.head_index;
      tail_index <= result.tail_index;
      length     <= result.length;
      peak       <= result.peak;
    end
  end

  `WSS_ASSERT(a_no_overwrite, clk, rst, (fire && emit) |-> out_free, "result register overwritten")
  `WSS_ASSERT(a_length_match, clk, rst, out_valid |-> ((LENGTH_W'(tail_index) - LENGTH_W'(head_index) + LENGTH_W'(1)) == length), "length does not match indexes")
  `WSS_ASSERT(a_length_min, clk, rst, out_valid |-> (length >= LENGTH_W'(2)), "waveset shorter than two samples")
  `WSS_ASSERT(a_ready_when_empty, clk, rst, !s1_valid |-> in_ready, "input register empty but not ready")
  `WSS_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> (!out_valid && !s1_valid), "registers not empty after reset")

endmodule
